>>> design/cte_pkg.sv
// cte_pkg: shared types, constants and the q30 multiply for the crack-tip
// enrichment evaluator
// no dependencies
package cte_pkg;

  // fixed-point format of the ports
  localparam int FRAC_BITS = 16;
  localparam int RAD_W     = 24;
  localparam int ANG_W     = 19;
  localparam int ORD_W     = 3;
  localparam int FUNC_W    = 22;
  localparam int GRAD_W    = 24;

  // internal q30 word
  localparam int Q30_FRAC = 30;
  localparam int Q_W      = 34;
  localparam int P_W      = 2 * Q_W;
  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q30_ONE     = 34'sd1073741824;
  localparam q_t Q30_HALF_PI = 34'sd1686629713;

  // saturation limits of the result words
  localparam q_t FUNC_MAX = q_t'((64'sd1 <<< (FUNC_W - 1)) - 1);
  localparam q_t FUNC_MIN = q_t'(-(64'sd1 <<< (FUNC_W - 1)));
  localparam q_t GRAD_MAX = q_t'((64'sd1 <<< (GRAD_W - 1)) - 1);
  localparam q_t GRAD_MIN = q_t'(-(64'sd1 <<< (GRAD_W - 1)));

  // branch function selector codes
  localparam logic [ORD_W-1:0] FUNC_SIN_HALF     = 3'd1;
  localparam logic [ORD_W-1:0] FUNC_COS_HALF     = 3'd2;
  localparam logic [ORD_W-1:0] FUNC_SIN_HALF_COS = 3'd3;
  localparam logic [ORD_W-1:0] FUNC_COS_HALF_COS = 3'd4;

  // register map, selected by paddr[2]
  localparam logic REG_FUNC_ORDER = 1'b0;
  localparam logic REG_TIP_INCL   = 1'b1;
  localparam int   ADDR_W         = 3;

  // square root: one result bit per stage
  localparam int L_SQRT = (RAD_W + FRAC_BITS + 1) / 2;
  localparam int V_PAD  = 2 * L_SQRT;
  localparam int SQ_W   = L_SQRT;
  localparam int REM_W  = SQ_W + 2;

  // reciprocal 2^(2F-1)/sqrt: one quotient bit per stage
  localparam int DV_STEPS = GRAD_W - 1;
  localparam int DIV_R0   = 2 ** (2 * FRAC_BITS - 1 - DV_STEPS);

  // pipeline stage map
  localparam int L_SC      = 19;
  localparam int ST_FAC    = L_SQRT + DV_STEPS;
  localparam int ST_TRIG   = ST_FAC - 4;
  localparam int ST_SC_IN  = ST_TRIG - L_SC;
  localparam int ST_OUT    = ST_FAC + 2;
  localparam int N_ST      = ST_OUT + 1;

  // a*b / 2^30, rounded to nearest, ties away from zero
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [P_W-1:0] p;
    logic [P_W-1:0] u;
    logic [Q_W-1:0] r;
    p = a * b;
    u = p[P_W-1] ? P_W'(-p) : P_W'(p);
    u = u + (P_W'(1) << (Q30_FRAC - 1));
    r = Q_W'(u >> Q30_FRAC);
    qmul = p[P_W-1] ? q_t'(-r) : q_t'(r);
  endfunction

endpackage

>>> design/cte_sincos.sv
// cte_sincos: pipelined sine and cosine of a q30 angle, quadrant reduction
// then taylor series by horner steps; depends on cte_pkg
module cte_sincos (
  input  logic          clk,
  input  logic          en,
  input  cte_pkg::q_t   angle,
  output cte_pkg::q_t   sine,
  output cte_pkg::q_t   cosine
);
  import cte_pkg::*;

  localparam int N_RED = 4;
  localparam int N_RND = 4;
  localparam int RCP_SH = 34;
  localparam longint unsigned RCP_ONE = 64'd17179869184;

  localparam logic [6:0]  SIN_DIV [N_RND] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0]  COS_DIV [N_RND] = '{7'd90, 7'd56, 7'd30, 7'd12};
  localparam logic [31:0] SIN_RCP [N_RND] = '{32'(RCP_ONE / 72), 32'(RCP_ONE / 42),
                                              32'(RCP_ONE / 20), 32'(RCP_ONE / 6)};
  localparam logic [31:0] COS_RCP [N_RND] = '{32'(RCP_ONE / 90), 32'(RCP_ONE / 56),
                                              32'(RCP_ONE / 30), 32'(RCP_ONE / 12)};

  // reduction stages
  q_t         rx [N_RED];
  logic [1:0] rk [N_RED];

  // carried values after the square stage
  q_t         cx [13];
  q_t         cz [13];
  logic [1:0] ck [14];

  // horner rounds
  logic [30:0] pr_s [N_RND];
  logic [30:0] pr_c [N_RND];
  logic [30:0] pv_s [N_RND];
  logic [30:0] pv_c [N_RND];
  logic [30:0] dq_s [N_RND];
  logic [30:0] dq_c [N_RND];
  q_t          ts   [N_RND];
  q_t          tc   [N_RND];

  q_t rs_r;
  q_t pc_r;

  // quarter-turn reduction, one step per stage
  for (genvar i = 0; i < N_RED; i++) begin : g_red
    q_t                    x_in;
    logic [1:0]            k_in;
    logic signed [Q_W:0]   x2;
    if (i == 0) begin : g_first
      assign x_in = angle;
      assign k_in = 2'd0;
    end else begin : g_next
      assign x_in = rx[i-1];
      assign k_in = rk[i-1];
    end
    assign x2 = {x_in, 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        if (x2 > (Q_W+1)'(Q30_HALF_PI)) begin
          rx[i] <= x_in - Q30_HALF_PI;
          rk[i] <= k_in + 2'd1;
        end else if (x2 < -(Q_W+1)'(Q30_HALF_PI)) begin
          rx[i] <= x_in + Q30_HALF_PI;
          rk[i] <= k_in - 2'd1;
        end else begin
          rx[i] <= x_in;
          rk[i] <= k_in;
        end
      end
    end
  end

  // square of the reduced angle
  always_ff @(posedge clk) begin
    if (en) begin
      cz[0] <= qmul(rx[N_RED-1], rx[N_RED-1]);
      cx[0] <= rx[N_RED-1];
      ck[0] <= rk[N_RED-1];
    end
  end

  // carry angle, square and quadrant alongside the rounds
  for (genvar i = 1; i < 13; i++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        cx[i] <= cx[i-1];
        cz[i] <= cz[i-1];
      end
    end
  end
  for (genvar i = 1; i < 14; i++) begin : g_carry_k
    always_ff @(posedge clk) begin
      if (en) ck[i] <= ck[i-1];
    end
  end

  // horner rounds: product, reciprocal multiply, correction
  for (genvar j = 0; j < N_RND; j++) begin : g_rnd
    q_t          ts_prev;
    q_t          tc_prev;
    q_t          ps;
    q_t          pc;
    logic [62:0] ms;
    logic [62:0] mc;
    logic [31:0] rr_s;
    logic [31:0] rr_c;
    logic [30:0] qs;
    logic [30:0] qc;
    if (j == 0) begin : g_first
      assign ts_prev = Q30_ONE;
      assign tc_prev = Q30_ONE;
    end else begin : g_next
      assign ts_prev = ts[j-1];
      assign tc_prev = tc[j-1];
    end
    assign ps = qmul(cz[3*j], ts_prev);
    assign pc = qmul(cz[3*j], tc_prev);
    assign ms = 63'(pr_s[j]) * 63'(SIN_RCP[j]);
    assign mc = 63'(pr_c[j]) * 63'(COS_RCP[j]);
    assign rr_s = 32'(pv_s[j]) - 32'(32'(dq_s[j]) * 32'(SIN_DIV[j]));
    assign rr_c = 32'(pv_c[j]) - 32'(32'(dq_c[j]) * 32'(COS_DIV[j]));
    assign qs = (rr_s >= 32'(SIN_DIV[j])) ? dq_s[j] + 31'd1 : dq_s[j];
    assign qc = (rr_c >= 32'(COS_DIV[j])) ? dq_c[j] + 31'd1 : dq_c[j];
    always_ff @(posedge clk) begin
      if (en) begin
        pr_s[j] <= ps[30:0];
        pr_c[j] <= pc[30:0];
        dq_s[j] <= 31'(ms >> RCP_SH);
        dq_c[j] <= 31'(mc >> RCP_SH);
        pv_s[j] <= pr_s[j];
        pv_c[j] <= pr_c[j];
        ts[j]   <= Q30_ONE - q_t'(qs);
        tc[j]   <= Q30_ONE - q_t'(qc);
      end
    end
  end

  // last products of both series
  always_ff @(posedge clk) begin
    if (en) begin
      rs_r <= qmul(cx[12], ts[N_RND-1]);
      pc_r <= qmul(cz[12], tc[N_RND-1]);
    end
  end

  // quadrant: signs and swap
  q_t rc;
  assign rc = Q30_ONE - (pc_r >>> 1);
  always_ff @(posedge clk) begin
    if (en) begin
      case (ck[13])
        2'd0: begin
          sine   <= rs_r;
          cosine <= rc;
        end
        2'd1: begin
          sine   <= rc;
          cosine <= -rs_r;
        end
        2'd2: begin
          sine   <= -rs_r;
          cosine <= -rc;
        end
        default: begin
          sine   <= -rc;
          cosine <= rs_r;
        end
      endcase
    end
  end

endmodule

>>> design/crack_tip_enrichment_eval_top.sv
// crack_tip_enrichment_eval_top: near-tip branch function and its global
// gradient for one polar point per cycle; depends on cte_pkg and cte_sincos
// throughput one word per cycle, set by the 20-stage square root and
// 23-stage reciprocal divider, each resolving one bit per stage; stall
// freezes the whole pipe
// reset clears the valid bits, function_order to 1, tip_inclination to 0
module crack_tip_enrichment_eval_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cte_pkg::RAD_W-1:0]            radius,
  input  logic signed [cte_pkg::ANG_W-1:0]     polar_angle,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cte_pkg::FUNC_W-1:0]    func_value,
  output logic signed [cte_pkg::GRAD_W-1:0]    grad_global_x,
  output logic signed [cte_pkg::GRAD_W-1:0]    grad_global_y,
  output logic                                 grad_saturated,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cte_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import cte_pkg::*;

  logic                      adv;
  logic [N_ST-1:0]           vld;
  logic [ORD_W-1:0]          function_order;
  logic signed [ANG_W-1:0]   tip_inclination;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      function_order  <= FUNC_SIN_HALF;
      tip_inclination <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TIP_INCL) tip_inclination <= pwdata[ANG_W-1:0];
      else function_order <= pwdata[ORD_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_TIP_INCL) ? 32'(tip_inclination)
                                             : 32'(function_order);

  // pipe advances unless a finished word is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[N_ST-2:0], in_valid};
  end

  // input register
  logic [RAD_W-1:0]        radius_r;
  logic signed [ANG_W-1:0] ang_d [ST_SC_IN+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      radius_r <= radius;
      ang_d[0] <= polar_angle;
    end
  end

  // angle waits until the trig units line up with the divider
  for (genvar i = 1; i <= ST_SC_IN; i++) begin : g_ang
    always_ff @(posedge clk) begin
      if (adv) ang_d[i] <= ang_d[i-1];
    end
  end

  // square root of radius << FRAC_BITS, one bit per stage
  logic [SQ_W-1:0]  sr_root [1:L_SQRT];
  logic [REM_W-1:0] sr_rem  [1:L_SQRT];
  logic [RAD_W-1:0] sr_rad  [1:L_SQRT-1];

  for (genvar k = 1; k <= L_SQRT; k++) begin : g_sqrt
    logic [SQ_W-1:0]   root_in;
    logic [REM_W-1:0]  rem_in;
    logic [RAD_W-1:0]  rad_in;
    logic [V_PAD-1:0]  vfull;
    logic [REM_W+1:0]  rem4;
    logic [REM_W+1:0]  trial;
    logic              take;
    if (k == 1) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = radius_r;
    end else begin : g_next
      assign root_in = sr_root[k-1];
      assign rem_in  = sr_rem[k-1];
      assign rad_in  = sr_rad[k-1];
    end
    assign vfull = V_PAD'({rad_in, {FRAC_BITS{1'b0}}});
    assign rem4  = {rem_in, vfull[V_PAD-2*k+1 -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign take  = rem4 >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_root[k] <= {root_in[SQ_W-2:0], take};
        sr_rem[k]  <= take ? REM_W'(rem4 - trial) : REM_W'(rem4);
      end
    end
    if (k < L_SQRT) begin : g_rad
      always_ff @(posedge clk) begin
        if (adv) sr_rad[k] <= rad_in;
      end
    end
  end

  // reciprocal 2^(2F-1) / root, restoring, one quotient bit per stage
  logic [SQ_W:0]       dv_rem [1:DV_STEPS-1];
  logic [DV_STEPS-1:0] dv_q   [1:DV_STEPS];
  logic [SQ_W-1:0]     dv_d   [1:DV_STEPS];
  logic                dv_sat [1:DV_STEPS];

  for (genvar j = 1; j <= DV_STEPS; j++) begin : g_div
    logic [SQ_W:0]       r_in;
    logic [DV_STEPS-1:0] q_in;
    logic [SQ_W-1:0]     d_in;
    logic                s_in;
    logic [SQ_W+1:0]     r2;
    logic                ge;
    if (j == 1) begin : g_first
      assign r_in = (SQ_W+1)'(DIV_R0);
      assign q_in = '0;
      assign d_in = sr_root[L_SQRT];
      assign s_in = sr_root[L_SQRT] <= SQ_W'(DIV_R0);
    end else begin : g_next
      assign r_in = dv_rem[j-1];
      assign q_in = dv_q[j-1];
      assign d_in = dv_d[j-1];
      assign s_in = dv_sat[j-1];
    end
    assign r2 = {r_in, 1'b0};
    assign ge = r2 >= (SQ_W+2)'(d_in);
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_q[j]   <= {q_in[DV_STEPS-2:0], ge};
        dv_d[j]   <= d_in;
        dv_sat[j] <= s_in;
      end
    end
    if (j < DV_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) dv_rem[j] <= ge ? (SQ_W+1)'(r2 - (SQ_W+2)'(d_in)) : (SQ_W+1)'(r2);
      end
    end
  end

  // trig units: half, full and three-half angle, tip inclination
  q_t ang_half;
  q_t sh, ch, st, ct, s3, c3, sa, ca;
  assign ang_half = q_t'(ang_d[ST_SC_IN]) <<< (Q30_FRAC - 1 - FRAC_BITS);

  cte_sincos u_half (
    .clk(clk), .en(adv), .angle(ang_half), .sine(sh), .cosine(ch)
  );
  cte_sincos u_full (
    .clk(clk), .en(adv), .angle(ang_half <<< 1), .sine(st), .cosine(ct)
  );
  cte_sincos u_three (
    .clk(clk), .en(adv), .angle(ang_half + ang_half + ang_half), .sine(s3), .cosine(c3)
  );
  cte_sincos u_incl (
    .clk(clk), .en(adv), .angle(q_t'(tip_inclination) <<< (Q30_FRAC - FRAC_BITS)),
    .sine(sa), .cosine(ca)
  );

  // first products of the branch terms
  q_t m_sh, m_ch, m_ct, m_st2, m_a3, m_a4, m_b3, m_b4, m_sa, m_ca;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_sh  <= sh;
      m_ch  <= ch;
      m_ct  <= ct;
      m_st2 <= qmul(st, st);
      m_a3  <= qmul(sh, ct);
      m_a4  <= qmul(ch, ct);
      m_b3  <= qmul(ct, c3);
      m_b4  <= qmul(ct, s3);
      m_sa  <= sa;
      m_ca  <= ca;
    end
  end

  // select the branch function and its local derivative terms
  q_t n_trig, n_t1, n_t2, n_sa, n_ca;
  q_t t1_3, t1_4;
  assign t1_3 = qmul(m_sh, (m_st2 <<< 1) - m_ct);
  assign t1_4 = qmul(m_ch, m_ct + (m_st2 <<< 1));
  always_ff @(posedge clk) begin
    if (adv) begin
      n_sa <= m_sa;
      n_ca <= m_ca;
      case (function_order)
        FUNC_SIN_HALF: begin
          n_trig <= m_sh;
          n_t1   <= -m_sh;
          n_t2   <= m_ch;
        end
        FUNC_COS_HALF: begin
          n_trig <= m_ch;
          n_t1   <= m_ch;
          n_t2   <= m_sh;
        end
        FUNC_SIN_HALF_COS: begin
          n_trig <= m_a3;
          n_t1   <= t1_3;
          n_t2   <= m_b3;
        end
        FUNC_COS_HALF_COS: begin
          n_trig <= m_a4;
          n_t1   <= t1_4;
          n_t2   <= -m_b4;
        end
        default: begin
          n_trig <= '0;
          n_t1   <= '0;
          n_t2   <= '0;
        end
      endcase
    end
  end

  // rotation into global axes
  q_t p_1, p_2, p_3, p_4, p_trig;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_1    <= qmul(n_t1, n_ca);
      p_2    <= qmul(n_t2, n_sa);
      p_3    <= qmul(n_t1, n_sa);
      p_4    <= qmul(n_t2, n_ca);
      p_trig <= n_trig;
    end
  end

  q_t g_x, g_y, g_trig;
  always_ff @(posedge clk) begin
    if (adv) begin
      g_x    <= p_1 - p_2;
      g_y    <= p_3 + p_4;
      g_trig <= p_trig;
    end
  end

  // scale by 0.5/sqrt(r) and sqrt(r)
  q_t   fac;
  q_t   mg_x, mg_y, mf;
  logic msat;
  assign fac = dv_sat[DV_STEPS] ? GRAD_MAX : q_t'(dv_q[DV_STEPS]);
  always_ff @(posedge clk) begin
    if (adv) begin
      mg_x <= qmul(fac, g_x);
      mg_y <= qmul(fac, g_y);
      mf   <= qmul(q_t'(dv_d[DV_STEPS]), g_trig);
      msat <= dv_sat[DV_STEPS];
    end
  end

  // clip and output register
  logic order_ok;
  logic hit_x, hit_y;
  logic signed [FUNC_W-1:0] fv_c;
  logic signed [GRAD_W-1:0] gx_c, gy_c;
  assign order_ok = (function_order == FUNC_SIN_HALF) || (function_order == FUNC_COS_HALF) ||
                    (function_order == FUNC_SIN_HALF_COS) ||
                    (function_order == FUNC_COS_HALF_COS);
  assign fv_c  = (mf > FUNC_MAX) ? FUNC_W'(FUNC_MAX) :
                 (mf < FUNC_MIN) ? FUNC_W'(FUNC_MIN) : FUNC_W'(mf);
  assign hit_x = (mg_x > GRAD_MAX) || (mg_x < GRAD_MIN);
  assign hit_y = (mg_y > GRAD_MAX) || (mg_y < GRAD_MIN);
  assign gx_c  = (mg_x > GRAD_MAX) ? GRAD_W'(GRAD_MAX) :
                 (mg_x < GRAD_MIN) ? GRAD_W'(GRAD_MIN) : GRAD_W'(mg_x);
  assign gy_c  = (mg_y > GRAD_MAX) ? GRAD_W'(GRAD_MAX) :
                 (mg_y < GRAD_MIN) ? GRAD_W'(GRAD_MIN) : GRAD_W'(mg_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (order_ok) begin
        func_value     <= fv_c;
        grad_global_x  <= gx_c;
        grad_global_y  <= gy_c;
        grad_saturated <= msat || hit_x || hit_y;
      end else begin
        func_value     <= '0;
        grad_global_x  <= '0;
        grad_global_y  <= '0;
        grad_saturated <= 1'b0;
      end
    end
  end

  // unknown function order gives an all-zero word
  a_bad_order_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !order_ok |->
      func_value == '0 && grad_global_x == '0 && grad_global_y == '0 && !grad_saturated)
    else $error("unknown function order gave a non-zero word");

  // a word in the stage before the output register reaches the output when the pipe moves
  a_word_reaches_out: assert property (@(posedge clk) disable iff (rst)
    vld[ST_OUT-1] && !in_stall |=> out_valid)
    else $error("word lost before the output register");

  // floor square root leaves a remainder of at most twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[L_SQRT] |-> sr_rem[L_SQRT] <= REM_W'({sr_root[L_SQRT], 1'b0}))
    else $error("square root remainder out of range");

endmodule
